@@ rtl/dnd_pkg.sv @@
// ---------------------------------------------------------------------------
// dnd_pkg
// Shared constants for the window null-draw block: seed mixing, LCG and
// scoring constants, default sizes.
// ---------------------------------------------------------------------------
package dnd_pkg;

   localparam int DEFAULT_WINDOW_CAPACITY = 16;
   localparam int DEFAULT_METRIC_COUNT    = 18;

   localparam int VALUE_W = 31;
   localparam int DRAW_W  = 21;
   localparam int KMER_W  = 16;

   localparam logic [VALUE_W-1:0] LCG_MUL        = 31'd1103515245;
   localparam logic [VALUE_W-1:0] LCG_INC        = 31'd12345;
   localparam logic [VALUE_W-1:0] SEED_START_MUL = 31'd1000003;
   localparam logic [VALUE_W-1:0] SEED_REC_MUL   = 31'd1000033;
   localparam logic [VALUE_W-1:0] SEED_FUNC_MUL  = 31'd100043;
   localparam logic [VALUE_W-1:0] SEED_REP_STEP  = 31'd1009;
   localparam logic [VALUE_W-1:0] PPM_SCALE      = 31'd1000000;

   localparam logic [6:0] MAX_DRAWS = 7'd64;

endpackage

@@ rtl/dnd_div.sv @@
// ---------------------------------------------------------------------------
// dnd_div
// Restoring divider, one quotient bit per cycle; shared by the shuffle
// modulo and the ppm scaling.
// ---------------------------------------------------------------------------
module dnd_div #(
   parameter int DIVIDEND_W = 31,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic                  ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/dna_window_null_draws_core.sv @@
// ---------------------------------------------------------------------------
// dna_window_null_draws_core
// Shuffled null draws for one window of DNA bases.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one window with its seeds and metric number; a transfer
//   takes place when req_valid and req_ready are both high. req_ready is high
//   only while the sequencer is idle.
//   rsp_* returns replicate_count draws (capped at 64) per window, the last
//   one flagged by rsp_last_draw. A draw sits in the output register until
//   taken; the sequencer waits while that draw is held and rsp_ready is low.
//   csr_* writes replicate_count (reset value 1); csr_ready is always high.
// Sequence:
//   seed states A to D and a check state per window, then per replicate a
//   setup state, len-1 swaps (LCG multiply, divider start and the modulo on
//   the shared divider), a state to end the shuffle, a build state, an orbit
//   step for each of the WINDOW_CAPACITY positions for k-mer metrics, ppm
//   scaling on the same divider and an emit state. Unavailable windows skip
//   the shuffle and scoring and go straight to the emit state. The next
//   window is taken once the last draw has entered the output register.
// Reset:
//   synchronous; clears the sequencer and the output valid and sets replicate_count to 1.
// ---------------------------------------------------------------------------
module dna_window_null_draws_core #(
   parameter int WINDOW_CAPACITY = dnd_pkg::DEFAULT_WINDOW_CAPACITY,
   parameter int METRIC_COUNT    = dnd_pkg::DEFAULT_METRIC_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_func,
   input  logic [31:0]        req_base_codes,
   input  logic [15:0]        req_invalid_mask,
   input  logic [4:0]         req_window_length,
   input  logic [4:0]         req_expected_length,
   input  logic [30:0]        req_seed_base,
   input  logic [30:0]        req_window_start,
   input  logic [30:0]        req_record_index,
   input  logic [4:0]         req_min_kmers,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [20:0] rsp_draw,
   output logic               rsp_last_draw,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);

   localparam int CAP = WINDOW_CAPACITY;
   localparam int IW  = $clog2(CAP);
   localparam int LW  = $clog2(CAP + 1);
   localparam int VW  = dnd_pkg::VALUE_W;
   localparam int KW  = dnd_pkg::KMER_W;
   localparam int DW  = dnd_pkg::DRAW_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SEED_A   = 4'd1;
   localparam logic [3:0] S_SEED_B   = 4'd2;
   localparam logic [3:0] S_SEED_C   = 4'd3;
   localparam logic [3:0] S_SEED_D   = 4'd4;
   localparam logic [3:0] S_AVAIL    = 4'd5;
   localparam logic [3:0] S_REP      = 4'd6;
   localparam logic [3:0] S_SHUF     = 4'd7;
   localparam logic [3:0] S_LCG      = 4'd8;
   localparam logic [3:0] S_MOD      = 4'd9;
   localparam logic [3:0] S_BUILD    = 4'd10;
   localparam logic [3:0] S_ORBIT    = 4'd11;
   localparam logic [3:0] S_PPM_MUL  = 4'd12;
   localparam logic [3:0] S_PPM_DIV  = 4'd13;
   localparam logic [3:0] S_PPM_WAIT = 4'd14;
   localparam logic [3:0] S_EMIT     = 4'd15;

   function automatic logic [KW-1:0] partner(input logic [KW-1:0] code,
                                             input logic [3:0] k,
                                             input logic comp);
      logic [KW-1:0] r;
      logic [1:0]    d;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         if (n < int'(k)) begin
            d = code[2*n +: 2];
            if (comp) d = ~d;
            r = {r[KW-3:0], d};
         end
      end
      return r;
   endfunction

   logic [3:0]    state_ff, state_in;
   logic [6:0]    rc_ff;
   logic [6:0]    reps_ff;
   logic [6:0]    rep_ff;
   logic [4:0]    func_ff;
   logic [4:0]    len_ff;
   logic [4:0]    exp_ff;
   logic [4:0]    min_ff;
   logic [VW-1:0] acc_ff;
   logic [VW-1:0] wstart_ff;
   logic [VW-1:0] rec_ff;
   logic [VW-1:0] rep_seed_ff;
   logic [VW-1:0] st_ff;
   logic [VW-1:0] prod_ff;
   logic          avail_ff;
   logic [IW-1:0] i_ff;
   logic [IW-1:0] p_ff;
   logic [LW-1:0] num_ff;
   logic [LW-1:0] den_ff;
   logic [DW-1:0] result_ff;
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_draw_ff;
   logic          rsp_last_ff;

   logic [1:0]    ob_ff [CAP];
   logic [CAP-1:0] ook_ff;
   logic [1:0]    wb_ff [CAP];
   logic [CAP-1:0] wk_ff;
   logic [KW-1:0] kcode_ff [CAP];
   logic [KW-1:0] korb_ff [CAP];
   logic [CAP-1:0] kval_ff;

   logic [2*CAP+31:0] codes_ext;
   logic [CAP+15:0]   mask_ext;

   logic [3:0]    k_sel;
   logic          comp_sel;
   logic [KW-1:0] kc [CAP];
   logic [KW-1:0] ko [CAP];
   logic [CAP-1:0] kv;
   logic [LW-1:0] kcnt;
   logic [CAP-1:0] mm;
   logic          pos_ok;
   logic [LW-1:0] mis;

   logic [KW-1:0] orb;
   logic [KW-1:0] op;
   logic [CAP-1:0] lm, rmask, sm;
   logic [LW-1:0] lcnt, rcnt, adiff;

   logic [VW-1:0] mul_a, mul_b;
   logic [2*VW-1:0] mul_full;
   logic [VW-1:0] lcg_val;

   logic          div_start;
   logic [VW-1:0] div_dividend;
   logic [LW-1:0] div_divisor;
   logic          div_done;
   logic [VW-1:0] div_quot;
   logic [LW-1:0] div_rem;
   logic [IW-1:0] j_idx;

   logic          accept;
   logic          emit_go;
   logic          last;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_draw      = rsp_draw_ff;
   assign rsp_last_draw = rsp_last_ff;

   assign codes_ext = {{(2*CAP){1'b0}}, req_base_codes};
   assign mask_ext  = {{CAP{1'b1}}, req_invalid_mask};

   assign k_sel    = func_ff[4:1];
   assign comp_sel = func_ff[0];

   // k-mer codes, orbits and validity per start position of the work window
   always_comb begin
      logic [KW-1:0] code;
      logic          good;
      for (int s = 0; s < CAP; s++) begin
         code = '0;
         good = 1'b1;
         for (int n = 0; n < 8; n++) begin
            if (n < int'(k_sel)) begin
               if (s + n < CAP) begin
                  code = {code[KW-3:0], wb_ff[s+n]};
                  good = good & wk_ff[s+n];
               end else begin
                  good = 1'b0;
               end
            end
         end
         kc[s] = code;
         ko[s] = (code < partner(code, k_sel, comp_sel)) ? code
                                                         : partner(code, k_sel, comp_sel);
         kv[s] = good && ((s + int'(k_sel)) <= int'(len_ff));
      end
      kcnt = LW'($countones(kv));
   end

   // positional mismatches against the mirrored window
   always_comb begin
      logic [5:0] pidx;
      logic [1:0] o;
      pos_ok = 1'b1;
      for (int n = 0; n < CAP; n++) begin
         pidx  = 6'(len_ff) - 6'(1) - 6'(n);
         o     = wb_ff[pidx[IW-1:0]];
         if (comp_sel) o = ~o;
         mm[n] = (n < int'(len_ff)) && (wb_ff[n] != o);
         if ((n < int'(len_ff)) && !wk_ff[n]) pos_ok = 1'b0;
      end
      mis = LW'($countones(mm));
   end

   // one orbit step: counts of the orbit at position p_ff over all positions
   always_comb begin
      orb = korb_ff[p_ff];
      op  = partner(orb, k_sel, comp_sel);
      for (int s = 0; s < CAP; s++) begin
         lm[s]    = kval_ff[s] && (kcode_ff[s] == orb);
         rmask[s] = kval_ff[s] && (kcode_ff[s] == op) && (op != orb);
         sm[s]    = (s < int'(p_ff)) && kval_ff[s] && (korb_ff[s] == orb);
      end
      lcnt  = LW'($countones(lm));
      rcnt  = LW'($countones(rmask));
      adiff = (lcnt >= rcnt) ? (lcnt - rcnt) : (rcnt - lcnt);
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_SEED_A:  begin mul_a = wstart_ff;    mul_b = dnd_pkg::SEED_START_MUL; end
         S_SEED_B:  begin mul_a = rec_ff;       mul_b = dnd_pkg::SEED_REC_MUL;   end
         S_SEED_C:  begin mul_a = VW'(func_ff); mul_b = dnd_pkg::SEED_FUNC_MUL;  end
         S_PPM_MUL: begin mul_a = VW'(num_ff);  mul_b = dnd_pkg::PPM_SCALE;      end
         default:   begin mul_a = st_ff;        mul_b = dnd_pkg::LCG_MUL;        end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign lcg_val  = VW'(prod_ff + dnd_pkg::LCG_INC);
   assign j_idx    = div_rem[IW-1:0];
   assign emit_go  = !rsp_valid_ff || rsp_ready;
   assign last     = (rep_ff == reps_ff);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = den_ff;
      if (state_ff == S_LCG) begin
         div_start    = 1'b1;
         div_dividend = lcg_val;
         div_divisor  = LW'(i_ff) + LW'(1);
      end else if (state_ff == S_PPM_DIV) begin
         div_start = 1'b1;
      end
   end

   dnd_div #(
      .DIVIDEND_W(VW),
      .DIVISOR_W (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_SEED_A;
         S_SEED_A:   state_in = S_SEED_B;
         S_SEED_B:   state_in = S_SEED_C;
         S_SEED_C:   state_in = S_SEED_D;
         S_SEED_D:   state_in = S_AVAIL;
         S_AVAIL:    state_in = (reps_ff == 7'd0) ? S_IDLE : S_REP;
         S_REP:      state_in = avail_ff ? S_SHUF : S_EMIT;
         S_SHUF:     state_in = (i_ff == '0) ? S_BUILD : S_LCG;
         S_LCG:      state_in = S_MOD;
         S_MOD:      if (div_done) state_in = S_SHUF;
         S_BUILD: begin
            if (func_ff < 5'd2)
               state_in = (len_ff == 5'd0) ? S_EMIT : S_PPM_MUL;
            else if ((int'(kcnt) < int'(min_ff)) || (kcnt == '0))
               state_in = S_EMIT;
            else
               state_in = S_ORBIT;
         end
         S_ORBIT:    if (p_ff == IW'(CAP - 1)) state_in = S_PPM_MUL;
         S_PPM_MUL:  state_in = S_PPM_DIV;
         S_PPM_DIV:  state_in = S_PPM_WAIT;
         S_PPM_WAIT: if (div_done) state_in = S_EMIT;
         S_EMIT:     if (emit_go) state_in = last ? S_IDLE : S_REP;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rc_ff        <= 7'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) rc_ff <= csr_data;
         if (state_ff == S_EMIT && emit_go)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end

      prod_ff <= mul_full[VW-1:0];

      if (accept) begin
         func_ff   <= req_func;
         len_ff    <= req_window_length;
         exp_ff    <= req_expected_length;
         min_ff    <= req_min_kmers;
         acc_ff    <= req_seed_base;
         wstart_ff <= req_window_start;
         rec_ff    <= req_record_index;
         reps_ff   <= (rc_ff > dnd_pkg::MAX_DRAWS) ? dnd_pkg::MAX_DRAWS : rc_ff;
         for (int n = 0; n < CAP; n++) begin
            ob_ff[n]  <= codes_ext[2*n +: 2];
            ook_ff[n] <= ~mask_ext[n];
            wb_ff[n]  <= codes_ext[2*n +: 2];
            wk_ff[n]  <= ~mask_ext[n];
         end
      end

      unique case (state_ff)
         S_SEED_B, S_SEED_C, S_SEED_D: acc_ff <= VW'(acc_ff + prod_ff);
         S_AVAIL: begin
            rep_ff      <= 7'd1;
            rep_seed_ff <= VW'(acc_ff + dnd_pkg::SEED_REP_STEP);
            if ((func_ff >= 5'(METRIC_COUNT)) || (int'(len_ff) > CAP))
               avail_ff <= 1'b0;
            else if (func_ff < 5'd2)
               avail_ff <= (len_ff == exp_ff) && pos_ok;
            else
               avail_ff <= (int'(kcnt) >= int'(min_ff)) && (kcnt != '0);
         end
         S_REP: begin
            st_ff     <= rep_seed_ff;
            result_ff <= '1;
            i_ff      <= (len_ff == 5'd0) ? '0 : IW'(len_ff - 5'd1);
            for (int n = 0; n < CAP; n++) begin
               wb_ff[n] <= ob_ff[n];
               wk_ff[n] <= ook_ff[n];
            end
         end
         S_LCG: st_ff <= lcg_val;
         S_MOD: begin
            if (div_done) begin
               // swap base and its valid flag at i and j
               if (j_idx != i_ff) begin
                  wb_ff[i_ff]  <= wb_ff[j_idx];
                  wb_ff[j_idx] <= wb_ff[i_ff];
                  wk_ff[i_ff]  <= wk_ff[j_idx];
                  wk_ff[j_idx] <= wk_ff[i_ff];
               end
               i_ff <= i_ff - IW'(1);
            end
         end
         S_BUILD: begin
            for (int n = 0; n < CAP; n++) begin
               kcode_ff[n] <= kc[n];
               korb_ff[n]  <= ko[n];
            end
            kval_ff <= kv;
            p_ff    <= '0;
            if (func_ff < 5'd2) begin
               num_ff <= mis;
               den_ff <= LW'(len_ff);
            end else begin
               num_ff <= '0;
               den_ff <= kcnt;
            end
         end
         S_ORBIT: begin
            // first occurrence of an orbit that is not self-paired adds |left-right|
            if (kval_ff[p_ff] && (sm == '0) && (op != orb))
               num_ff <= num_ff + adiff;
            p_ff <= p_ff + IW'(1);
         end
         S_PPM_WAIT: if (div_done) result_ff <= div_quot[DW-1:0];
         S_EMIT: begin
            if (emit_go) begin
               rsp_draw_ff <= result_ff;
               rsp_last_ff <= last;
               rep_ff      <= rep_ff + 7'd1;
               rep_seed_ff <= VW'(rep_seed_ff + dnd_pkg::SEED_REP_STEP);
            end
         end
         default: ;
      endcase
   end

endmodule

@@ dv/dna_window_null_draws_core_tb.sv @@
// ---------------------------------------------------------------------------
// dna_window_null_draws_core_tb
// Self-checking bench for the window null-draw block. Windows are pushed
// through the request channel, and each one is scored here by shuffling
// it the same way the block does. Every returned draw is then checked
// against the oldest predicted draw. The bench covers several replicate
// counts, including zero and the saturating top. Both channels idle at
// random, and there is a long receiver hold-off and a sender drain pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dna_window_null_draws_core_tb;

   localparam int CAP     = 16;
   localparam int METRICS = 18;

   typedef struct packed {
      logic [4:0]  fn;
      logic [31:0] codes;
      logic [15:0] mask;
      logic [4:0]  len;
      logic [4:0]  exp_len;
      logic [30:0] seed;
      logic [30:0] wstart;
      logic [30:0] rec;
      logic [4:0]  min_kmers;
   } window_type;

   typedef struct packed {
      logic signed [20:0] draw;
      logic               last;
   } draw_type;

   typedef logic [1:0] base_arr_type [CAP];
   typedef bit         ok_arr_type   [CAP];

   class draw_scoreboard;
      draw_type draws_due[$];
      int       errors;
      int       reported;
      bit [6:0] reps_reg;

      function new();
         errors   = 0;
         reported = 0;
         reps_reg = 7'd1;
      endfunction

      function automatic int unsigned partner(int unsigned code, int k, bit comp);
         int unsigned r;
         int unsigned d;
         r = 0;
         for (int i = 0; i < k; i++) begin
            d = code & 3;
            if (comp) d = 3 - d;
            r = (r << 2) | d;
            code = code >> 2;
         end
         return r;
      endfunction

      function automatic int mismatch_score(base_arr_type b, int len, bit comp);
         int unsigned mis;
         int unsigned o;
         mis = 0;
         if (len == 0) return -1;
         for (int i = 0; i < len; i++) begin
            o = b[len-1-i];
            if (comp) o = 3 - o;
            if (b[i] != o) mis++;
         end
         return int'((longint'(mis) * 1000000) / len);
      endfunction

      function automatic int orbit_skew(base_arr_type b, ok_arr_type ok, int len, int k,
                                        bit comp, int minimum);
         int unsigned kc[CAP];
         int unsigned cnt, num, den, c, p, orb, op, q, po, left, right;
         bit good, seen;
         cnt = 0; num = 0; den = 0;
         for (int s = 0; s + k <= len && s < CAP; s++) begin
            good = 1;
            c = 0;
            for (int i = 0; i < k; i++) begin
               if (!ok[s+i]) good = 0;
               c = (c << 2) | b[s+i];
            end
            if (good) begin
               kc[cnt] = c;
               cnt++;
            end
         end
         if (cnt < minimum) return -1;
         for (int i = 0; i < cnt; i++) begin
            p   = partner(kc[i], k, comp);
            orb = kc[i] < p ? kc[i] : p;
            seen = 0;
            for (int j = 0; j < i; j++) begin
               q  = partner(kc[j], k, comp);
               po = kc[j] < q ? kc[j] : q;
               if (po == orb) seen = 1;
            end
            if (!seen) begin
               op = partner(orb, k, comp);
               left = 0; right = 0;
               for (int j = 0; j < cnt; j++) begin
                  if (kc[j] == orb) left++;
                  else if (op != orb && kc[j] == op) right++;
               end
               if (op == orb) begin
                  den += left;
               end else begin
                  num += left >= right ? left - right : right - left;
                  den += left + right;
               end
            end
         end
         if (den == 0) return -1;
         return int'((longint'(num) * 1000000) / den);
      endfunction

      function automatic int window_score(base_arr_type b, ok_arr_type ok, int len, int fn,
                                          int minimum);
         if (fn < 2) return mismatch_score(b, len, fn == 1);
         return orbit_skew(b, ok, len, fn / 2, fn[0], minimum);
      endfunction

      // predict every draw of one accepted window
      function void note_window(window_type w);
         base_arr_type b, sb;
         ok_arr_type   ok, sk;
         bit           avail;
         int           reps, len, fn, d, jj;
         longint unsigned st;
         logic [1:0]   tmp_b;
         bit           tmp_k;
         draw_type     e;
         reps = reps_reg > dnd_pkg::MAX_DRAWS ? dnd_pkg::MAX_DRAWS : reps_reg;
         len  = w.len;
         fn   = w.fn;
         for (int i = 0; i < CAP; i++) begin
            b[i]  = w.codes[2*i +: 2];
            ok[i] = !w.mask[i];
         end
         if (fn >= METRICS || len > CAP) begin
            avail = 0;
         end else if (fn < 2) begin
            avail = (len == w.exp_len);
            for (int i = 0; i < len; i++)
               if (!ok[i]) avail = 0;
         end else begin
            avail = window_score(b, ok, len, fn, w.min_kmers) >= 0;
         end
         for (int r = 1; r <= reps; r++) begin
            d = -1;
            if (avail) begin
               st = (longint'(w.seed) + longint'(w.wstart) * dnd_pkg::SEED_START_MUL
                     + longint'(w.rec) * dnd_pkg::SEED_REC_MUL
                     + longint'(fn) * dnd_pkg::SEED_FUNC_MUL
                     + longint'(r) * dnd_pkg::SEED_REP_STEP) & 64'h7fffffff;
               sb = b;
               sk = ok;
               for (int i = CAP - 1; i > 0; i--) begin
                  if (i < len) begin
                     st = (st * dnd_pkg::LCG_MUL + dnd_pkg::LCG_INC) & 64'h7fffffff;
                     jj = int'(st % (i + 1));
                     tmp_b = sb[i]; sb[i] = sb[jj]; sb[jj] = tmp_b;
                     tmp_k = sk[i]; sk[i] = sk[jj]; sk[jj] = tmp_k;
                  end
               end
               d = window_score(sb, sk, len, fn, w.min_kmers);
            end
            e.draw = d[20:0];
            e.last = (r == reps);
            draws_due.push_back(e);
         end
      endfunction

      function void fail(string msg);
         errors++;
         if (reported < 10) begin
            reported++;
            $display("mismatch: %s", msg);
         end
      endfunction

      function void check_draw(logic signed [20:0] draw, logic last);
         draw_type e;
         if (draws_due.size() == 0) begin
            fail($sformatf("unexpected draw %0d last %0b", draw, last));
            return;
         end
         e = draws_due.pop_front();
         if (draw !== e.draw)
            fail($sformatf("draw expected %0d actual %0d", e.draw, draw));
         if (last !== e.last)
            fail($sformatf("last_draw expected %0b actual %0b", e.last, last));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [4:0]         req_func;
   logic [31:0]        req_base_codes;
   logic [15:0]        req_invalid_mask;
   logic [4:0]         req_window_length;
   logic [4:0]         req_expected_length;
   logic [30:0]        req_seed_base;
   logic [30:0]        req_window_start;
   logic [30:0]        req_record_index;
   logic [4:0]         req_min_kmers;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [20:0] rsp_draw;
   logic               rsp_last_draw;
   logic               csr_valid;
   logic               csr_ready;
   logic [6:0]         csr_data;

   draw_scoreboard sb;
   bit calm;
   bit hold_rx;

   dna_window_null_draws_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_base_codes      (req_base_codes),
      .req_invalid_mask    (req_invalid_mask),
      .req_window_length   (req_window_length),
      .req_expected_length (req_expected_length),
      .req_seed_base       (req_seed_base),
      .req_window_start    (req_window_start),
      .req_record_index    (req_record_index),
      .req_min_kmers       (req_min_kmers),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_draw            (rsp_draw),
      .rsp_last_draw       (rsp_last_draw),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #500000000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever @(posedge clock) begin
         if (hold_rx) begin
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
            hold_rx = 1'b0;
         end else begin
            rsp_ready <= !reset && (calm || $urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_draw(rsp_draw, rsp_last_draw);
   end

   task automatic send_window(window_type w);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_func            <= w.fn;
      req_base_codes      <= w.codes;
      req_invalid_mask    <= w.mask;
      req_window_length   <= w.len;
      req_expected_length <= w.exp_len;
      req_seed_base       <= w.seed;
      req_window_start    <= w.wstart;
      req_record_index    <= w.rec;
      req_min_kmers       <= w.min_kmers;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_window(w);
   endtask

   task automatic drain(int extra);
      req_valid <= 1'b0;
      while (sb.draws_due.size() > 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reps(logic [6:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.reps_reg = v;
   endtask

   function automatic window_type rand_window();
      window_type w;
      int pick;
      w.fn = 5'($urandom_range(99) < 90 ? $urandom_range(0, METRICS - 1)
                                        : $urandom_range(METRICS, 31));
      pick = $urandom_range(99);
      if (pick < 70)      w.len = 5'($urandom_range(1, 10));
      else if (pick < 90) w.len = 5'($urandom_range(11, CAP));
      else if (pick < 95) w.len = 5'd0;
      else                w.len = 5'($urandom_range(CAP + 1, 31));
      w.exp_len = (w.fn < 2 && $urandom_range(99) < 85) ? w.len
                                                         : 5'($urandom_range(0, 31));
      pick = $urandom_range(99);
      if (pick < 70)      w.mask = '0;
      else if (pick < 90) w.mask = 16'd1 << $urandom_range(0, 15);
      else                w.mask = 16'($urandom);
      w.min_kmers = 5'($urandom_range(99) < 75 ? $urandom_range(0, w.len > 16 ? 16 : w.len)
                                               : $urandom_range(0, 31));
      w.codes  = $urandom;
      w.seed   = 31'($urandom);
      w.wstart = 31'($urandom);
      w.rec    = 31'($urandom);
      return w;
   endfunction

   function automatic window_type plain_window(int fn, int len);
      window_type w;
      w = rand_window();
      w.fn        = 5'(fn);
      w.len       = 5'(len);
      w.exp_len   = 5'(len);
      w.mask      = '0;
      w.min_kmers = 5'd0;
      return w;
   endfunction

   initial begin
      window_type w;
      logic [6:0] phase_reps [5];
      sb = new();
      calm    = 1'b0;
      hold_rx = 1'b0;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_func            <= '0;
      req_base_codes      <= '0;
      req_invalid_mask    <= '0;
      req_window_length   <= '0;
      req_expected_length <= '0;
      req_seed_base       <= '0;
      req_window_start    <= '0;
      req_record_index    <= '0;
      req_min_kmers       <= '0;
      csr_valid           <= 1'b0;
      csr_data            <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every metric on a full window at the reset replicate count
      for (int f = 0; f < METRICS; f++) send_window(plain_window(f, CAP));
      send_window(plain_window(0, 0));               // zero length positional
      w = plain_window(0, 8); w.exp_len = 9;         // length mismatch
      send_window(w);
      w = plain_window(1, 6); w.mask = 16'h0004;     // invalid base in window
      send_window(w);
      send_window(plain_window(METRICS, 8));         // metric out of range
      send_window(plain_window(31, 8));
      send_window(plain_window(4, 31));              // length above capacity
      w = plain_window(17, CAP); w.min_kmers = 31;   // too few k-mers
      send_window(w);
      w = plain_window(3, CAP);
      w.codes = '1; w.mask = '1; w.seed = '1; w.wstart = '1; w.rec = '1;
      send_window(w);
      w = plain_window(2, CAP); w.seed = '1; w.wstart = '1; w.rec = '1; w.exp_len = '1;
      send_window(w);
      drain(20);

      // zero replicates: nothing comes back
      write_reps(7'd0);
      for (int i = 0; i < 3; i++) send_window(rand_window());
      drain(2000);

      // saturating count, mostly short windows
      write_reps(7'd127);
      send_window(plain_window(0, 2));
      send_window(plain_window(5, 3));
      drain(20);
      write_reps(7'd64);
      send_window(plain_window(9, CAP));
      send_window(plain_window(20, 4));
      drain(20);

      phase_reps[0] = 7'd3;
      phase_reps[1] = 7'd1;
      phase_reps[2] = 7'd8;
      phase_reps[3] = 7'd2;
      phase_reps[4] = 7'd5;
      for (int p = 0; p < 5; p++) begin
         write_reps(phase_reps[p]);
         calm = (p == 1);
         for (int i = 0; i < 64; i++) begin
            if (p == 0 && i == 5) hold_rx = 1'b1;
            if (p == 3 && i == 30) drain(0);
            send_window(rand_window());
         end
         calm = 1'b0;
         drain(20);
      end

      drain(200);
      if (sb.errors == 0 && sb.draws_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
